>>> hw/rtl/cgf_pkg.sv
// Shared types, constants and step functions for the central gravity force core.
// Used by cgf_sqrt_pipe, cgf_div_pipe and central_gravity_force_core.
`default_nettype none

package cgf_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_ATTRACTION = 3'd3,
    REG_CENTER_ID  = 3'd4,
    REG_RECIPROCAL = 3'd5
  } cgf_reg_e;

  localparam int unsigned ID_W     = 20;
  localparam int unsigned MAG_W    = 31;  // normalized magnitude, [2^30, 2^31) for the largest
  localparam int unsigned LEN_W    = 32;  // floor(sqrt(sum of squares))
  localparam int unsigned SUM_W    = 64;

  localparam int unsigned SQRT_STEPS     = 32;
  localparam int unsigned SQRT_PER_STAGE = 2;
  localparam int unsigned SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

  localparam int unsigned DIV_STEPS     = 31;
  localparam int unsigned DIV_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  typedef struct packed {
    logic [SUM_W-1:0] x;  // remaining radicand
    logic [SUM_W-1:0] r;  // partial root
  } cgf_sq_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [MAG_W-1:0] quo;
  } cgf_dv_t;

  // one digit of the shift-subtract square root, bit = 4^(31-k)
  function automatic cgf_sq_t sqrt_step(cgf_sq_t s, logic [4:0] k);
    cgf_sq_t        o;
    logic [SUM_W-1:0] bitv;
    logic [SUM_W-1:0] t;
    bitv = {{(SUM_W-1){1'b0}}, 1'b1} << (6'd62 - {k, 1'b0});
    t    = s.r + bitv;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one quotient bit of restoring division
  function automatic cgf_dv_t div_step(cgf_dv_t s, logic [LEN_W-1:0] len, logic nbit);
    cgf_dv_t        o;
    logic [LEN_W:0] sh;
    sh = {s.rem, nbit};
    if (sh >= {1'b0, len}) begin
      o.rem = LEN_W'(sh - {1'b0, len});
      o.quo = {s.quo[MAG_W-2:0], 1'b1};
    end else begin
      o.rem = sh[LEN_W-1:0];
      o.quo = {s.quo[MAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cgf_sqrt_pipe.sv
// Pipelined 64-bit integer square root, two result bits per stage.
// Depends on cgf_pkg (sqrt_step, stage counts).
`default_nettype none

module cgf_sqrt_pipe import cgf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [SUM_W-1:0] x_i,
  output logic      [LEN_W-1:0] root_o
);

  cgf_sq_t st_q [SQRT_STAGES];
  cgf_sq_t st_d [SQRT_STAGES];

  always_comb begin
    cgf_sq_t cur;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        cur.x = x_i;
        cur.r = '0;
      end else begin
        cur = st_q[s-1];
      end
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        cur = sqrt_step(cur, 5'(s * SQRT_PER_STAGE + j));
      end
      st_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_STAGES; s++) st_q[s] <= st_d[s];
    end
  end

  assign root_o = st_q[SQRT_STAGES-1].r[LEN_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/cgf_div_pipe.sv
// Pipelined restoring divider: floor(mag * 2^30 / len), quotient below 2^31.
// Depends on cgf_pkg (div_step, stage counts).
`default_nettype none

module cgf_div_pipe import cgf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [MAG_W-1:0] mag_i,
  input  wire logic [LEN_W-1:0] len_i,
  output logic      [MAG_W-1:0] quo_o
);

  cgf_dv_t          st_q  [DIV_STAGES];
  cgf_dv_t          st_d  [DIV_STAGES];
  logic [LEN_W-1:0] len_q [DIV_STAGES];

  always_comb begin
    cgf_dv_t          cur;
    logic [LEN_W-1:0] l;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        // quotient bits above 30 are zero, so start from mag/2
        cur.rem = LEN_W'(mag_i >> 1);
        cur.quo = '0;
        l       = len_i;
      end else begin
        cur = st_q[s-1];
        l   = len_q[s-1];
      end
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        if (s * DIV_PER_STAGE + j < DIV_STEPS) begin
          cur = div_step(cur, l, (s == 0 && j == 0) ? mag_i[0] : 1'b0);
        end
      end
      st_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        st_q[s]  <= st_d[s];
        len_q[s] <= (s == 0) ? len_i : len_q[s-1];
      end
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

>>> hw/rtl/central_gravity_force_core.sv
// Central gravity force core: per-body force toward a configured center point.
// Depends on cgf_pkg, cgf_sqrt_pipe and cgf_div_pipe.
//
// One body enters per cycle while the output register accepts. A body's result
// passes through 4 front stages, 16 square-root stages, 8 divider stages and 2
// multiply and saturate stages. The pipeline moves as one under a common enable
// set by the output register: in reciprocal mode a body makes two result
// transfers, so the input is held while the reaction force is due, and the
// sustained rate is one body per cycle without reaction forces. Absent bodies,
// clumps and the central body still pass through but give no result.
`default_nettype none

module central_gravity_force_core import cgf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration writes
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  // body stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // body_id[19:0], pos_x[51:20], pos_y[83:52], pos_z[115:84], body_mass[147:116]
  input  wire logic [151:0] s_axis_tdata_i,
  // body_present[0], body_is_clump[1]
  input  wire logic [1:0]   s_axis_tuser_i,
  // force stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // target_id[19:0], force_x[51:20], force_y[83:52], force_z[115:84]
  output logic [119:0]      m_axis_tdata_o,
  output logic              m_axis_tlast_o
);

  localparam int unsigned FW = 64 - FRAC_BITS;  // force scalar width
  localparam int unsigned FH = FW - 32;         // upper part of force scalar
  localparam int unsigned CW = FH + 34;         // component magnitude width

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic                    skip;
    logic                    zero;
    logic [2:0]              dneg;
    logic [FW-1:0]           fmag;
    logic [2:0][MAG_W-1:0]   mag;
  } pl_t;

  // ---------------- configuration registers
  logic [31:0]     cx_q, cy_q, cz_q, att_q;
  logic [ID_W-1:0] cid_q;
  logic            rec_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      att_q <= '0;
      cid_q <= '0;
      rec_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cgf_reg_e'(cfg_index_i))
        REG_CENTER_X:   cx_q  <= cfg_data_i;
        REG_CENTER_Y:   cy_q  <= cfg_data_i;
        REG_CENTER_Z:   cz_q  <= cfg_data_i;
        REG_ATTRACTION: att_q <= cfg_data_i;
        REG_CENTER_ID:  cid_q <= cfg_data_i[ID_W-1:0];
        REG_RECIPROCAL: rec_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable
  logic out_valid_q, phase_q, orec_q;
  logic adv;

  assign adv             = !out_valid_q || (m_axis_tready_i && (phase_q || !orec_q));
  assign s_axis_tready_o = adv;

  // ---------------- stage 1: differences, magnitudes, force scalar
  logic [ID_W-1:0] in_id;
  logic [2:0][31:0] in_pos, cen;
  logic [31:0]     in_mass, att_abs;
  logic [2:0][32:0] d_s1, mag_s1;
  logic [2:0]      dneg_s1;
  logic [63:0]     pm_s1;

  assign in_id     = s_axis_tdata_i[19:0];
  assign in_pos[0] = s_axis_tdata_i[51:20];
  assign in_pos[1] = s_axis_tdata_i[83:52];
  assign in_pos[2] = s_axis_tdata_i[115:84];
  assign in_mass   = s_axis_tdata_i[147:116];
  assign cen[0]    = cx_q;
  assign cen[1]    = cy_q;
  assign cen[2]    = cz_q;
  assign att_abs   = att_q[31] ? 32'(-att_q) : att_q;
  assign pm_s1     = 64'(att_abs) * 64'(in_mass);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_s1[i]    = {cen[i][31], cen[i]} - {in_pos[i][31], in_pos[i]};
      dneg_s1[i] = d_s1[i][32];
      mag_s1[i]  = d_s1[i][32] ? 33'(-d_s1[i]) : d_s1[i];
    end
  end

  logic             p1_v_q;
  logic [ID_W-1:0]  p1_id_q;
  logic             p1_skip_q;
  logic [2:0]       p1_dneg_q;
  logic [FW-1:0]    p1_fmag_q;
  logic [2:0][32:0] p1_mag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_id_q   <= in_id;
      p1_skip_q <= !s_axis_tuser_i[0] || s_axis_tuser_i[1] || (in_id == cid_q);
      p1_dneg_q <= dneg_s1;
      p1_fmag_q <= pm_s1[63:FRAC_BITS];
      p1_mag_q  <= mag_s1;
    end
  end

  // ---------------- stage 2: normalize largest magnitude into [2^30, 2^31)
  logic [32:0]         mx;
  logic [5:0]          msb;
  logic [2:0][MAG_W-1:0] nmag;

  always_comb begin
    mx = (p1_mag_q[0] > p1_mag_q[1]) ? p1_mag_q[0] : p1_mag_q[1];
    mx = (p1_mag_q[2] > mx) ? p1_mag_q[2] : mx;
    msb = '0;
    for (int b = 0; b < 33; b++) begin
      if (mx[b]) msb = 6'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (msb > 6'd30) nmag[i] = MAG_W'(p1_mag_q[i] >> (msb - 6'd30));
      else             nmag[i] = MAG_W'(p1_mag_q[i] << (6'd30 - msb));
    end
  end

  logic p2_v_q;
  pl_t  p2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q.id   <= p1_id_q;
      p2_q.skip <= p1_skip_q;
      p2_q.zero <= (mx == '0);
      p2_q.dneg <= p1_dneg_q;
      p2_q.fmag <= p1_fmag_q;
      p2_q.mag  <= nmag;
    end
  end

  // ---------------- stage 3: squares, stage 4: sum
  logic            p3_v_q, p4_v_q;
  pl_t             p3_q, p4_q;
  logic [2:0][61:0] sq_q;
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_q <= p2_q;
      for (int i = 0; i < 3; i++) sq_q[i] <= 62'(p2_q.mag[i]) * 62'(p2_q.mag[i]);
      p4_q  <= p3_q;
      sum_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
  end

  // ---------------- square root with payload alongside
  logic [LEN_W-1:0] root;
  pl_t              sq_pl_q [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] sq_v_q;

  cgf_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (sum_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_pl_q[0] <= p4_q;
      for (int s = 1; s < SQRT_STAGES; s++) sq_pl_q[s] <= sq_pl_q[s-1];
    end
  end

  // ---------------- three dividers for the unit vector
  pl_t                   sq_out;
  logic [2:0][MAG_W-1:0] unit;
  pl_t                   dv_pl_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] dv_v_q;

  assign sq_out = sq_pl_q[SQRT_STAGES-1];

  for (genvar g = 0; g < 3; g++) begin : g_div
    cgf_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .mag_i (sq_out.mag[g]),
      .len_i (root),
      .quo_o (unit[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_pl_q[0] <= sq_out;
      for (int s = 1; s < DIV_STAGES; s++) dv_pl_q[s] <= dv_pl_q[s-1];
    end
  end

  // ---------------- multiply by force scalar
  pl_t                    dv_out;
  logic                   mu_v_q;
  pl_t                    mu_q;
  logic [2:0][FH+30:0]    mhi_q;
  logic [2:0][62:0]       mlo_q;

  assign dv_out = dv_pl_q[DIV_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_q <= dv_out;
      for (int i = 0; i < 3; i++) begin
        mhi_q[i] <= (FH+31)'(dv_out.fmag[FW-1:32]) * (FH+31)'(unit[i]);
        mlo_q[i] <= 63'(dv_out.fmag[31:0]) * 63'(unit[i]);
      end
    end
  end

  // ---------------- sign and saturation
  logic [2:0][CW-1:0] cmag;
  logic [2:0][31:0]   fpos, fneg, fbody, freac;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = mu_q.zero ? '0
              : CW'({mhi_q[i], 2'b00}) + CW'(mlo_q[i][62:30]);
      fpos[i] = (cmag[i][CW-1:31] != '0) ? 32'h7fff_ffff : cmag[i][31:0];
      fneg[i] = (cmag[i][CW-1:31] != '0) ? 32'h8000_0000 : 32'(-cmag[i][31:0]);
      if (mu_q.dneg[i] != att_q[31]) begin
        fbody[i] = fneg[i];
        freac[i] = fpos[i];
      end else begin
        fbody[i] = fpos[i];
        freac[i] = fneg[i];
      end
    end
  end

  // ---------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      sq_v_q <= '0;
      dv_v_q <= '0;
      mu_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= s_axis_tvalid_i;
      p2_v_q <= p1_v_q && !p1_skip_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      sq_v_q <= {sq_v_q[SQRT_STAGES-2:0], p4_v_q};
      dv_v_q <= {dv_v_q[DIV_STAGES-2:0], sq_v_q[SQRT_STAGES-1]};
      mu_v_q <= dv_v_q[DIV_STAGES-1];
    end
  end

  // ---------------- output register: body force, then reaction force
  logic [ID_W-1:0]  oid_q, ocid_q;
  logic [2:0][31:0] of_q, or_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      orec_q      <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mu_v_q;
      phase_q     <= 1'b0;
      orec_q      <= rec_q;
    end else if (m_axis_tready_i) begin
      // body force taken while a reaction is due
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oid_q  <= mu_q.id;
      ocid_q <= cid_q;
      of_q   <= fbody;
      or_q   <= freac;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = phase_q || !orec_q;
  assign m_axis_tdata_o  = phase_q ? {4'b0, or_q[2], or_q[1], or_q[0], ocid_q}
                                   : {4'b0, of_q[2], of_q[1], of_q[0], oid_q};

  // ---------------- assertions
  a_reac_needs_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && phase_q |-> orec_q)
    else $error("reaction phase without reciprocal mode");

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> out_valid_q)
    else $error("input stalled with empty output register");

  a_reac_follows_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !phase_q && orec_q && m_axis_tready_i |=> out_valid_q && phase_q)
    else $error("reaction force not issued after body force");

endmodule

`default_nettype wire
